// ===== hdl/frame_port_route_table_unit_defines.svh =====
// Assertion macros shared by the route table RTL.
// No dependencies.
`ifndef FRAME_PORT_ROUTE_TABLE_UNIT_DEFINES_SVH
`define FRAME_PORT_ROUTE_TABLE_UNIT_DEFINES_SVH

// Check that a condition implies a consequence on the same edge.
`define FPRT_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define FPRT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fprt_pkg.sv =====
// Shared types and constants for the port route table.
// No dependencies.
`timescale 1ns / 1ps
package fprt_pkg;
    localparam int SLOT_COUNT = 8;
    localparam int MAX_DIGIS = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);
    localparam int ADDR_W = 52;
    localparam int QDEPTH = 2;

    localparam logic [1:0] CMD_ROUTE   = 2'd0;
    localparam logic [1:0] CMD_REG     = 2'd1;
    localparam logic [1:0] CMD_REM     = 2'd2;
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    localparam logic [2:0] MODE_STATIC  = 3'd0;
    localparam logic [2:0] MODE_DEFAULT = 3'd1;
    localparam logic [2:0] MODE_PROMISC = 3'd2;
    localparam logic [2:0] MODE_DIGI    = 3'd3;
    localparam logic [2:0] MODE_DYNAMIC = 3'd4;

    localparam logic [1:0] KIND_STATUS   = 2'd0;
    localparam logic [1:0] KIND_DELIVERY = 2'd1;
    localparam logic [1:0] KIND_NONE     = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXISTS  = 3'd1;
    localparam logic [2:0] ST_DEFAULT = 3'd2;
    localparam logic [2:0] ST_DUPADDR = 3'd3;
    localparam logic [2:0] ST_NOSLOT  = 3'd4;
    localparam logic [2:0] ST_NOTFND  = 3'd5;

    localparam logic [7:0] NUL_CHAR = 8'h00;

    // Classified request handed from front to back
    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        handle;
        logic [2:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] fsrc;
        logic              has_next;
        logic [2:0]        nidx;
        logic [ADDR_W-1:0] next_addr;
    } req_t;
endpackage

// ===== hdl/frame_port_route_table_unit.sv =====
// Port route table top level: front queue plus slot table back end.
// Depends on fprt_pkg, fprt_front, fprt_back.
`timescale 1ns / 1ps
//
//  channel   handshake         payload
//  request   start / busy      command .. next_digi_address
//  result    result_valid      kind .. last (one cycle, no stall)
//
// Register and remove walk the slots (one slot checked per
// cycle); a rejection or a remove hit ends the walk at that slot.
// Route walks the slots in passes:
// bind pass, match pass, optional default pass, each one slot per cycle.
// A two-entry queue decouples accept from the slot walk; busy when it is full.
// Reset clears all slots and the queue; slot payload is not reset.
// The receiver cannot stall results.
module frame_port_route_table_unit
    import fprt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [7:0]        port_handle,
    input  logic [2:0]        port_mode,
    input  logic [ADDR_W-1:0] port_address,
    input  logic [ADDR_W-1:0] frame_destination,
    input  logic [ADDR_W-1:0] frame_source,
    input  logic [3:0]        digi_count,
    input  logic [7:0]        repeated_mask,
    input  logic [ADDR_W-1:0] next_digi_address,
    output logic              result_valid,
    output logic [1:0]        kind,
    output logic [2:0]        status,
    output logic [7:0]        target_handle,
    output logic [2:0]        target_slot,
    output logic              mark_repeated,
    output logic [2:0]        repeated_index,
    output logic              last
);
    logic q_valid, q_pop;
    req_t q_data;

    fprt_front u_front (
        .clk, .rst_n, .start, .busy, .command, .port_handle, .port_mode,
        .port_address, .frame_destination, .frame_source, .digi_count,
        .repeated_mask, .next_digi_address, .q_valid, .q_data, .q_pop
    );

    fprt_back u_back (
        .clk, .rst_n, .q_valid, .q_data, .q_pop, .result_valid, .kind,
        .status, .target_handle, .target_slot, .mark_repeated,
        .repeated_index, .last
    );
endmodule

// ===== hdl/fprt_front.sv =====
// Front end: accepts requests, finds the pending digipeater, queues them.
// Depends on fprt_pkg.
`timescale 1ns / 1ps
`include "frame_port_route_table_unit_defines.svh"
module fprt_front
    import fprt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [7:0]        port_handle,
    input  logic [2:0]        port_mode,
    input  logic [ADDR_W-1:0] port_address,
    input  logic [ADDR_W-1:0] frame_destination,
    input  logic [ADDR_W-1:0] frame_source,
    input  logic [3:0]        digi_count,
    input  logic [7:0]        repeated_mask,
    input  logic [ADDR_W-1:0] next_digi_address,
    output logic              q_valid,
    output req_t              q_data,
    input  logic              q_pop
);
    req_t q_mem_reg [QDEPTH];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic [3:0] cnt_clamp;
    logic       hn;
    logic [2:0] ni;
    req_t       req;

    always_comb
    begin
        cnt_clamp = (digi_count > 4'(MAX_DIGIS)) ? 4'(MAX_DIGIS) : digi_count;
        hn = 1'b0;
        ni = '0;
        for (int d = 7; d >= 0; d--)
        begin
            if (4'(d) < cnt_clamp && !repeated_mask[d])
            begin
                hn = 1'b1;
                ni = 3'(d);
            end
        end
        req.command   = command;
        req.handle    = port_handle;
        req.mode      = port_mode;
        req.address   = port_address;
        req.dest      = frame_destination;
        req.fsrc      = frame_source;
        req.has_next  = hn;
        req.nidx      = ni;
        req.next_addr = next_digi_address;
    end

    // Drop unknown commands here; they cause no result.
    assign busy = (count_reg == 2'(QDEPTH));
    assign push = start && !busy && (command != CMD_IGNORED);
    assign q_valid = (count_reg != 2'd0);
    assign q_data = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 2'd1;
        else if (!push && q_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= req;
    end

    `FPRT_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, q_pop, q_valid, "pop from empty queue")
    `FPRT_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, count_reg <= 2'(QDEPTH), "queue overflow")
    `FPRT_ASSERT_NEXT(a_push_grow, clk, rst_n, push && !q_pop, count_reg != 2'd0, "push lost")
endmodule

// ===== hdl/fprt_back.sv =====
// Back end: owns the slot table and walks slots to produce results.
// Depends on fprt_pkg.
`timescale 1ns / 1ps
`include "frame_port_route_table_unit_defines.svh"
module fprt_back
    import fprt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  req_t              q_data,
    output logic              q_pop,
    output logic              result_valid,
    output logic [1:0]        kind,
    output logic [2:0]        status,
    output logic [7:0]        target_handle,
    output logic [2:0]        target_slot,
    output logic              mark_repeated,
    output logic [2:0]        repeated_index,
    output logic              last
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_BIND  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DEF   = 3'd4;
    localparam logic [2:0] S_END   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [SLOT_COUNT-1:0] used_reg, retired_reg;
    logic [7:0]        hnd_mem [SLOT_COUNT];
    logic [2:0]        mode_mem [SLOT_COUNT];
    logic [ADDR_W-1:0] addr_mem [SLOT_COUNT];

    logic [2:0]        state_reg;
    req_t              req_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [RES_W-1:0]  k_reg;
    logic              matched_reg;
    logic              free_found_reg, ret_found_reg;
    logic [SLOT_W-1:0] free_slot_reg, ret_slot_reg;

    // Pending delivery held so the final one can carry last
    logic              pend_reg;
    logic [7:0]        pend_h_reg;
    logic [2:0]        pend_s_reg;
    logic              pend_m_reg;
    logic [2:0]        pend_i_reg;

    logic [SLOT_W-1:0] idx;
    logic [7:0]        sh;
    logic [2:0]        sm;
    logic [ADDR_W-1:0] sa;
    logic              su, bound, elig, isdef;
    logic              rem_hit, reg_clash, hit, result_valid_next;

    assign idx   = idx_reg[SLOT_W-1:0];
    assign sh    = hnd_mem[idx];
    assign sm    = mode_mem[idx];
    assign sa    = addr_mem[idx];
    assign su    = used_reg[idx];
    assign bound = (sa[ADDR_W-1 -: 8] != NUL_CHAR);
    assign isdef = su && sh != req_reg.handle && sm == MODE_DEFAULT;

    always_comb
    begin
        case (sm)
            MODE_PROMISC: elig = 1'b1;
            MODE_DIGI:    elig = req_reg.has_next && sa == req_reg.next_addr;
            MODE_STATIC:  elig = !req_reg.has_next && sa == req_reg.dest;
            MODE_DYNAMIC: elig = bound && !req_reg.has_next && sa == req_reg.dest;
            default:      elig = 1'b0;
        endcase
        elig = elig && su && sh != req_reg.handle;
    end

    logic at_end;
    assign at_end = (idx_reg == CNT_W'(SLOT_COUNT - 1));
    assign q_pop = (state_reg == S_IDLE) && q_valid;

    assign rem_hit   = req_reg.command == CMD_REM && su && sh == req_reg.handle;
    assign reg_clash = req_reg.command == CMD_REG && su &&
                       (sh == req_reg.handle ||
                        (req_reg.mode == MODE_DEFAULT && sm == MODE_DEFAULT) ||
                        ((req_reg.mode == MODE_STATIC || req_reg.mode == MODE_DIGI) &&
                         (sm == MODE_STATIC || sm == MODE_DIGI) &&
                         sa == req_reg.address));
    assign hit = ((state_reg == S_SCAN) ? elig : isdef) && k_reg < RES_W'(MAX_RESULTS);

    // Strobe a result on a status decision, on a flushed delivery, and at the end
    always_comb
    begin
        result_valid_next = 1'b0;
        case (state_reg)
            S_CHECK:       result_valid_next = rem_hit || reg_clash;
            S_END, S_FIN:  result_valid_next = 1'b1;
            S_SCAN, S_DEF: result_valid_next = hit && pend_reg;
            default:       result_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            retired_reg    <= '0;
            result_valid   <= 1'b0;
            pend_reg       <= 1'b0;
            idx_reg        <= '0;
            k_reg          <= '0;
            matched_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            ret_found_reg  <= 1'b0;
        end
        else
        begin
            result_valid <= result_valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        req_reg        <= q_data;
                        idx_reg        <= '0;
                        k_reg          <= '0;
                        matched_reg    <= 1'b0;
                        free_found_reg <= 1'b0;
                        ret_found_reg  <= 1'b0;
                        pend_reg       <= 1'b0;
                        state_reg      <= (q_data.command == CMD_ROUTE) ? S_BIND : S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (rem_hit)
                    begin
                        used_reg[idx]    <= 1'b0;
                        retired_reg[idx] <= 1'b1;
                        kind <= KIND_STATUS; status <= ST_OK;
                        target_handle <= req_reg.handle; target_slot <= 3'(idx);
                        mark_repeated <= 1'b0; repeated_index <= '0; last <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (reg_clash)
                    begin
                        kind <= KIND_STATUS;
                        status <= (sh == req_reg.handle) ? ST_EXISTS :
                                  (req_reg.mode == MODE_DEFAULT && sm == MODE_DEFAULT)
                                  ? ST_DEFAULT : ST_DUPADDR;
                        target_handle <= req_reg.handle; target_slot <= '0;
                        mark_repeated <= 1'b0; repeated_index <= '0; last <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (!su && !retired_reg[idx] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_slot_reg  <= idx;
                        end
                        if (!su && retired_reg[idx] && !ret_found_reg)
                        begin
                            ret_found_reg <= 1'b1;
                            ret_slot_reg  <= idx;
                        end
                        if (at_end)
                            state_reg <= S_END;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_END:
                begin
                    // Finish a register or a remove that found nothing
                    kind <= KIND_STATUS;
                    target_handle <= req_reg.handle;
                    mark_repeated <= 1'b0; repeated_index <= '0; last <= 1'b1;
                    target_slot <= (req_reg.command != CMD_REM &&
                                    (free_found_reg || ret_found_reg))
                                   ? 3'(free_found_reg ? free_slot_reg : ret_slot_reg)
                                   : 3'd0;
                    if (req_reg.command == CMD_REM)
                        status <= ST_NOTFND;
                    else if (free_found_reg || ret_found_reg)
                    begin
                        status <= ST_OK;
                        used_reg[free_found_reg ? free_slot_reg : ret_slot_reg] <= 1'b1;
                        retired_reg[free_found_reg ? free_slot_reg : ret_slot_reg] <= 1'b0;
                    end
                    else
                        status <= ST_NOSLOT;
                    state_reg <= S_IDLE;
                end
                S_BIND:
                begin
                    if (at_end)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_SCAN, S_DEF:
                begin
                    if (hit)
                    begin
                        if (pend_reg)
                        begin
                            kind <= KIND_DELIVERY; status <= ST_OK;
                            target_handle <= pend_h_reg; target_slot <= pend_s_reg;
                            mark_repeated <= pend_m_reg; repeated_index <= pend_i_reg;
                            last <= 1'b0;
                        end
                        pend_reg   <= 1'b1;
                        pend_h_reg <= sh;
                        pend_s_reg <= 3'(idx);
                        pend_m_reg <= (state_reg == S_SCAN) && sm == MODE_DIGI
                                      && req_reg.has_next;
                        pend_i_reg <= ((state_reg == S_SCAN) && sm == MODE_DIGI
                                      && req_reg.has_next) ? req_reg.nidx : 3'd0;
                        k_reg <= k_reg + 1'b1;
                    end
                    if (state_reg == S_SCAN && elig &&
                        (sm == MODE_STATIC || sm == MODE_DIGI || sm == MODE_DYNAMIC))
                        matched_reg <= 1'b1;
                    if (!at_end)
                        idx_reg <= idx_reg + 1'b1;
                    else
                    begin
                        idx_reg <= '0;
                        if (state_reg == S_SCAN && !(matched_reg ||
                            (elig && (sm == MODE_STATIC || sm == MODE_DIGI ||
                                      sm == MODE_DYNAMIC))))
                            state_reg <= S_DEF;
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    // Flush the held delivery with last, or report no target
                    kind <= pend_reg ? KIND_DELIVERY : KIND_NONE;
                    status <= ST_OK;
                    target_handle <= pend_reg ? pend_h_reg : 8'd0;
                    target_slot <= pend_reg ? pend_s_reg : 3'd0;
                    mark_repeated <= pend_reg && pend_m_reg;
                    repeated_index <= pend_reg ? pend_i_reg : 3'd0;
                    last <= 1'b1;
                    pend_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Table payload writes: register fill and dynamic bind
    always_ff @(posedge clk)
    begin
        if (state_reg == S_END && req_reg.command == CMD_REG &&
            (free_found_reg || ret_found_reg))
        begin
            hnd_mem[free_found_reg ? free_slot_reg : ret_slot_reg]  <= req_reg.handle;
            mode_mem[free_found_reg ? free_slot_reg : ret_slot_reg] <= req_reg.mode;
            addr_mem[free_found_reg ? free_slot_reg : ret_slot_reg] <= req_reg.address;
        end
        else if (state_reg == S_BIND && su && sh == req_reg.handle &&
                 sm == MODE_DYNAMIC && !bound)
            addr_mem[idx] <= req_reg.fsrc;
    end

    `FPRT_ASSERT_IMPL(a_pop_idle, clk, rst_n, q_pop, state_reg == S_IDLE, "pop while working")
    `FPRT_ASSERT_NEXT(a_fin_last, clk, rst_n, state_reg == S_FIN, result_valid && last, "no last")
    `FPRT_ASSERT_IMPL(a_k_range, clk, rst_n, 1'b1, k_reg <= RES_W'(MAX_RESULTS), "too many results")
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the port route table unit.
// Depends on fprt_pkg and frame_port_route_table_unit.
`timescale 1ns / 1ps
module tb_top;
    import fprt_pkg::*;

    // Settle time after the last result: the longest route walk plus slack.
    localparam int DRAIN_CYCLES = 3 * SLOT_COUNT + 40;
    localparam int CYCLE_LIMIT  = 200000;

    // One request as the sender drives it
    typedef struct {
        logic [1:0]        cmd;
        logic [7:0]        handle;
        logic [2:0]        mode;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] fsrc;
        logic [3:0]        cnt;
        logic [7:0]        mask;
        logic [ADDR_W-1:0] next;
    } port_request_t;

    // One result as the block presents it
    typedef struct {
        logic [1:0] kind;
        logic [2:0] status;
        logic [7:0] handle;
        logic [2:0] slot;
        logic       mark;
        logic [2:0] ridx;
        logic       last;
    } route_result_t;

    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam logic [ADDR_W-1:0] ADDR_A1 = 52'h4E_3141_4141_4_1;
    localparam logic [ADDR_W-1:0] ADDR_A2 = 52'h4B_3232_3232_3_0;
    localparam logic [ADDR_W-1:0] ADDR_A3 = 52'h57_3343_4343_4_F;
    localparam logic [ADDR_W-1:0] ADDR_D1 = 52'h44_4947_4931_2_2;
    localparam logic [ADDR_W-1:0] ADDR_S1 = 52'h53_5243_5331_3_7;
    localparam logic [ADDR_W-1:0] ADDR_LO = 52'h00_1234_5678_9_A;
    localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        command;
    logic [7:0]        port_handle;
    logic [2:0]        port_mode;
    logic [ADDR_W-1:0] port_address;
    logic [ADDR_W-1:0] frame_destination;
    logic [ADDR_W-1:0] frame_source;
    logic [3:0]        digi_count;
    logic [7:0]        repeated_mask;
    logic [ADDR_W-1:0] next_digi_address;
    logic              result_valid;
    logic [1:0]        kind;
    logic [2:0]        status;
    logic [7:0]        target_handle;
    logic [2:0]        target_slot;
    logic              mark_repeated;
    logic [2:0]        repeated_index;
    logic              last;

    frame_port_route_table_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .command           (command),
        .port_handle       (port_handle),
        .port_mode         (port_mode),
        .port_address      (port_address),
        .frame_destination (frame_destination),
        .frame_source      (frame_source),
        .digi_count        (digi_count),
        .repeated_mask     (repeated_mask),
        .next_digi_address (next_digi_address),
        .result_valid      (result_valid),
        .kind              (kind),
        .status            (status),
        .target_handle     (target_handle),
        .target_slot       (target_slot),
        .mark_repeated     (mark_repeated),
        .repeated_index    (repeated_index),
        .last              (last)
    );

    // Shadow copy of the slot table
    logic              tbl_used    [SLOT_COUNT];
    logic              tbl_retired [SLOT_COUNT];
    logic [7:0]        tbl_handle  [SLOT_COUNT];
    logic [2:0]        tbl_mode    [SLOT_COUNT];
    logic [ADDR_W-1:0] tbl_addr    [SLOT_COUNT];

    route_result_t pending_results[$];
    int            mismatches;
    int            idle_pct;
    int            cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: give up long after the slowest legal run would have ended.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic bit is_bound(logic [ADDR_W-1:0] a);
        return a[ADDR_W-1 -: 8] != NUL_CHAR;
    endfunction

    function automatic route_result_t status_result(logic [2:0] st, logic [7:0] h,
                                                    logic [2:0] slot);
        route_result_t r;
        r = '{KIND_STATUS, st, h, slot, 1'b0, 3'd0, 1'b1};
        return r;
    endfunction

    // Register: reject on the first conflicting used slot, else allocate a
    // fresh slot ahead of a retired one.
    task automatic predict_register(port_request_t q);
        int  slot;
        bit  addr_mode;
        slot = -1;
        addr_mode = (q.mode == MODE_STATIC) || (q.mode == MODE_DIGI);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!tbl_used[i])
                continue;
            if (tbl_handle[i] == q.handle)
            begin
                pending_results.push_back(status_result(ST_EXISTS, q.handle, 3'd0));
                return;
            end
            if (q.mode == MODE_DEFAULT && tbl_mode[i] == MODE_DEFAULT)
            begin
                pending_results.push_back(status_result(ST_DEFAULT, q.handle, 3'd0));
                return;
            end
            if (addr_mode && (tbl_mode[i] == MODE_STATIC || tbl_mode[i] == MODE_DIGI)
                && tbl_addr[i] == q.addr)
            begin
                pending_results.push_back(status_result(ST_DUPADDR, q.handle, 3'd0));
                return;
            end
        end
        for (int i = 0; i < SLOT_COUNT && slot < 0; i++)
            if (!tbl_used[i] && !tbl_retired[i])
                slot = i;
        for (int i = 0; i < SLOT_COUNT && slot < 0; i++)
            if (!tbl_used[i] && tbl_retired[i])
                slot = i;
        if (slot < 0)
        begin
            pending_results.push_back(status_result(ST_NOSLOT, q.handle, 3'd0));
            return;
        end
        tbl_used[slot]    = 1'b1;
        tbl_retired[slot] = 1'b0;
        tbl_handle[slot]  = q.handle;
        tbl_mode[slot]    = q.mode;
        tbl_addr[slot]    = q.addr;
        pending_results.push_back(status_result(ST_OK, q.handle, slot[2:0]));
    endtask

    task automatic predict_remove(port_request_t q);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (tbl_used[i] && tbl_handle[i] == q.handle)
            begin
                tbl_used[i]    = 1'b0;
                tbl_retired[i] = 1'b1;
                pending_results.push_back(status_result(ST_OK, q.handle, i[2:0]));
                return;
            end
        end
        pending_results.push_back(status_result(ST_NOTFND, q.handle, 3'd0));
    endtask

    // Route: bind the source if it is an unbound dynamic port, then list the
    // eligible slots, falling back to default ports when nothing matched.
    task automatic predict_route(port_request_t q);
        route_result_t copies[$];
        route_result_t r;
        int            cnt;
        bit            has_next;
        bit            matched;
        logic [2:0]    nidx;
        bit            ok;
        has_next = 1'b0;
        matched  = 1'b0;
        nidx     = 3'd0;
        cnt = (q.cnt > MAX_DIGIS) ? MAX_DIGIS : q.cnt;
        for (int d = 0; d < cnt; d++)
        begin
            if (!q.mask[d])
            begin
                has_next = 1'b1;
                nidx = d[2:0];
                break;
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++)
            if (tbl_used[i] && tbl_handle[i] == q.handle && tbl_mode[i] == MODE_DYNAMIC
                && !is_bound(tbl_addr[i]))
                tbl_addr[i] = q.fsrc;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!tbl_used[i] || tbl_handle[i] == q.handle)
                continue;
            case (tbl_mode[i])
                MODE_PROMISC: ok = 1'b1;
                MODE_DIGI:    ok = has_next && tbl_addr[i] == q.next;
                MODE_STATIC:  ok = !has_next && tbl_addr[i] == q.dest;
                MODE_DYNAMIC: ok = is_bound(tbl_addr[i]) && !has_next
                                   && tbl_addr[i] == q.dest;
                default:      ok = 1'b0;
            endcase
            if (!ok)
                continue;
            if (tbl_mode[i] != MODE_PROMISC)
                matched = 1'b1;
            r = '{KIND_DELIVERY, ST_OK, tbl_handle[i], i[2:0], 1'b0, 3'd0, 1'b0};
            if (tbl_mode[i] == MODE_DIGI)
            begin
                r.mark = 1'b1;
                r.ridx = nidx;
            end
            if (copies.size() < MAX_RESULTS)
                copies.push_back(r);
        end
        if (!matched)
            for (int i = 0; i < SLOT_COUNT; i++)
                if (tbl_used[i] && tbl_handle[i] != q.handle && tbl_mode[i] == MODE_DEFAULT
                    && copies.size() < MAX_RESULTS)
                    copies.push_back('{KIND_DELIVERY, ST_OK, tbl_handle[i], i[2:0],
                                       1'b0, 3'd0, 1'b0});
        if (copies.size() == 0)
            copies.push_back('{KIND_NONE, ST_OK, 8'd0, 3'd0, 1'b0, 3'd0, 1'b1});
        copies[copies.size() - 1].last = 1'b1;
        foreach (copies[i])
            pending_results.push_back(copies[i]);
    endtask

    // Drive one request from a falling edge, hold it until the block takes
    // it, then update the shadow table.
    task automatic send_request(port_request_t q);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        command           = q.cmd;
        port_handle       = q.handle;
        port_mode         = q.mode;
        port_address      = q.addr;
        frame_destination = q.dest;
        frame_source      = q.fsrc;
        digi_count        = q.cnt;
        repeated_mask     = q.mask;
        next_digi_address = q.next;
        start             = 1'b1;
        // busy only moves at a rising edge, so its value here holds for the next one
        while (busy)
            @(negedge clk);
        @(posedge clk);
        case (q.cmd)
            CMD_ROUTE: predict_route(q);
            CMD_REG:   predict_register(q);
            CMD_REM:   predict_remove(q);
            default:   ;
        endcase
    endtask

    function automatic port_request_t reg_req(logic [7:0] h, logic [2:0] m,
                                              logic [ADDR_W-1:0] a);
        port_request_t q;
        q = '{CMD_REG, h, m, a, ~a, a, 4'd0, 8'h00, ~a};
        return q;
    endfunction

    function automatic port_request_t rem_req(logic [7:0] h);
        port_request_t q;
        q = '{CMD_REM, h, MODE_UNUSED, ADDR_ONES, ADDR_ONES, ADDR_ONES, 4'hF, 8'hFF,
              ADDR_ONES};
        return q;
    endfunction

    function automatic port_request_t route_req(logic [7:0] src, logic [ADDR_W-1:0] dest,
                                                logic [ADDR_W-1:0] fsrc, logic [3:0] cnt,
                                                logic [7:0] mask,
                                                logic [ADDR_W-1:0] next);
        port_request_t q;
        q = '{CMD_ROUTE, src, MODE_STATIC, 52'd0, dest, fsrc, cnt, mask, next};
        return q;
    endfunction

    // Mostly a small set of addresses so that matches and duplicates happen
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return ADDR_A1;
            1:       return ADDR_A2;
            2:       return ADDR_A3;
            3:       return ADDR_D1;
            4:       return ADDR_S1;
            5:       return ADDR_LO;
            6:       return 52'd0;
            default: return w[ADDR_W-1:0];
        endcase
    endfunction

    function automatic port_request_t random_req();
        port_request_t q;
        logic [63:0]   w;
        int            pick;
        w = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        q.cmd    = (pick < 50) ? CMD_ROUTE : (pick < 80) ? CMD_REG
                 : (pick < 97) ? CMD_REM : CMD_IGNORED;
        q.handle = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 11))
                                              : 8'($urandom_range(0, 255));
        q.mode   = 3'($urandom_range(0, 7));
        q.addr   = pick_addr();
        q.dest   = pick_addr();
        q.fsrc   = ($urandom_range(0, 1) == 0) ? pick_addr() : w[ADDR_W-1:0];
        q.cnt    = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
        q.mask   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'((1 << $urandom_range(0, 8)) - 1);
        q.next   = pick_addr();
        return q;
    endfunction

    // Compare every strobed result with the oldest expectation.
    always @(posedge clk)
    begin
        route_result_t e;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d handle=%0d slot=%0d",
                             kind, target_handle, target_slot);
            end
            else
            begin
                e = pending_results.pop_front();
                if (kind !== e.kind || status !== e.status || target_handle !== e.handle
                    || target_slot !== e.slot || mark_repeated !== e.mark
                    || repeated_index !== e.ridx || last !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp k%0d s%0d h%0d t%0d m%0d r%0d l%0d",
                                  " got k%0d s%0d h%0d t%0d m%0d r%0d l%0d"},
                                 e.kind, e.status, e.handle, e.slot, e.mark, e.ridx,
                                 e.last, kind, status, target_handle, target_slot,
                                 mark_repeated, repeated_index, last);
                end
            end
        end
    end

    // Fill the table, hitting every rejection reason and the full case.
    task automatic test_register_rules();
        send_request(reg_req(8'd0, MODE_STATIC, ADDR_A1));
        send_request(reg_req(8'd255, MODE_DEFAULT, ADDR_ONES));
        send_request(reg_req(8'd0, MODE_PROMISC, ADDR_A2));
        send_request(reg_req(8'd9, MODE_DEFAULT, ADDR_A2));
        send_request(reg_req(8'd3, MODE_DIGI, ADDR_A1));
        send_request(reg_req(8'd3, MODE_DIGI, ADDR_D1));
        send_request(reg_req(8'd4, MODE_DYNAMIC, 52'd0));
        send_request(reg_req(8'd5, MODE_PROMISC, ADDR_LO));
        send_request(reg_req(8'd6, MODE_UNUSED, ADDR_A2));
        send_request(reg_req(8'd7, MODE_STATIC, ADDR_A2));
        send_request(reg_req(8'd8, MODE_STATIC, ADDR_A3));
        send_request(reg_req(8'd10, MODE_STATIC, ADDR_S1));
    endtask

    // Binding, digipeater marking, clamped count and the default fallback.
    task automatic test_route_delivery();
        send_request(route_req(8'd4, ADDR_A1, ADDR_S1, 4'd0, 8'h00, ADDR_D1));
        send_request(route_req(8'd1, ADDR_S1, ADDR_A1, 4'd0, 8'h00, ADDR_D1));
        send_request(route_req(8'd5, ADDR_LO, ADDR_LO, 4'd0, 8'h00, ADDR_D1));
        send_request(route_req(8'd255, ADDR_A1, ADDR_A1, 4'd3, 8'h03, ADDR_D1));
        send_request(route_req(8'd2, ADDR_ONES, ADDR_ONES, 4'd15, 8'hFF, ADDR_D1));
        send_request(route_req(8'd2, ADDR_A2, 52'd0, 4'd8, 8'h7F, ADDR_D1));
    endtask

    // Free a slot, miss an unknown handle, route to nothing, reuse the slot.
    task automatic test_remove_and_reuse();
        port_request_t q;
        send_request(rem_req(8'd5));
        send_request(rem_req(8'd200));
        send_request(route_req(8'd255, 52'd0, 52'd0, 4'd0, 8'h00, 52'd0));
        send_request(reg_req(8'd11, MODE_STATIC, ADDR_S1));
        q = rem_req(8'd0);
        q.cmd = CMD_IGNORED;
        send_request(q);
    endtask

    task automatic test_random_traffic(int n, int pct);
        idle_pct = pct;
        repeat (n)
            send_request(random_req());
    endtask

    initial
    begin
        rst_n             = 1'b0;
        start             = 1'b0;
        command           = CMD_ROUTE;
        port_handle       = 8'd0;
        port_mode         = MODE_STATIC;
        port_address      = '0;
        frame_destination = '0;
        frame_source      = '0;
        digi_count        = 4'd0;
        repeated_mask     = 8'd0;
        next_digi_address = '0;
        mismatches        = 0;
        idle_pct          = 0;
        cycles            = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            tbl_used[i]    = 1'b0;
            tbl_retired[i] = 1'b0;
            tbl_handle[i]  = 8'd0;
            tbl_mode[i]    = MODE_STATIC;
            tbl_addr[i]    = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_pct = 25;
        test_register_rules();
        test_route_delivery();
        test_remove_and_reuse();
        test_random_traffic(99, 25);
        test_random_traffic(99, 80);
        test_random_traffic(99, 0);

        @(negedge clk);
        start = 1'b0;
        // Drain: wait for every expected result, then let stragglers show up.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
